/* src/iou_trk_pkg.sv */
// iou_trk_pkg: shared widths, codes, track record and sequencer states
// for the iou region tracker; no dependencies
`timescale 1ns / 1ps

package iou_trk_pkg;

  localparam int CoordW       = 20;
  localparam int AreaW        = 40;
  localparam int FrameW       = 16;
  localparam int RatioW       = 9;
  localparam int MissW        = 8;
  localparam int FramesW      = 8;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 16;
  localparam int OutLimit     = 16;
  localparam int OutCntW      = $clog2(OutLimit + 1);
  localparam int MaxTracksDef = 16;

  // register reset values
  localparam logic [FrameW-1:0] FwRst     = 16'd1920;
  localparam logic [FrameW-1:0] FhRst     = 16'd1080;
  localparam logic [RatioW-1:0] IouSlowRst = 9'd77;
  localparam logic [RatioW-1:0] IouFastRst = 9'd38;
  localparam logic [FrameW-1:0] MinSpdRst  = 16'd32;
  localparam logic [MissW-1:0]  EvRst      = 8'd3;
  localparam logic [MissW-1:0]  EvMovRst   = 8'd6;
  localparam logic [RatioW-1:0] BlendRst   = 9'd179;

  typedef enum logic [1:0] {
    FN_DETECT    = 2'd0,
    FN_END_FRAME = 2'd1,
    FN_PREDICT   = 2'd2,
    FN_CLEAR     = 2'd3
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FW      = 3'd0,
    REG_FH      = 3'd1,
    REG_ISLOW   = 3'd2,
    REG_IFAST   = 3'd3,
    REG_MINSPD  = 3'd4,
    REG_EV      = 3'd5,
    REG_EVMOV   = 3'd6,
    REG_BLEND   = 3'd7
  } reg_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_D_CHK, ST_D_RD, ST_D_PRED, ST_D_INT, ST_D_MUL, ST_D_UNI, ST_D_DIV, ST_D_CMP,
    ST_D_DEC, ST_B_MUL1, ST_B_MUL2, ST_B_DIV, ST_B_WR,
    ST_E_RD, ST_E_UPD,
    ST_H_RD, ST_H_UPD,
    ST_X_RD, ST_X_CHK, ST_X_END
  } state_e;

  typedef struct packed {
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
    logic [CoordW-1:0] size_w;
    logic [CoordW-1:0] size_h;
    logic [CoordW-1:0] vel_x;
    logic [CoordW-1:0] vel_y;
    logic [MissW-1:0]  miss;
    logic              hit;
  } track_t;

endpackage

/* src/iou_region_tracker.sv */
// iou_region_tracker: track table in one synchronous memory, driven by a sequencer
// detection: a read, predict, intersect, area, union, serial divide and compare per track;
// a match adds a blend with serial divides; end of frame ages and compacts, then lists
// hold predict moves each track, then lists; one item at a time
// reset: registers take their defaults, table is empty, no clearing pass
`timescale 1ns / 1ps

module iou_region_tracker #(
  parameter int MAX_TRACKS = iou_trk_pkg::MaxTracksDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [iou_trk_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [iou_trk_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [1:0]                           func_i,
  input  logic signed [iou_trk_pkg::CoordW-1:0] rect_x_i,
  input  logic signed [iou_trk_pkg::CoordW-1:0] rect_y_i,
  input  logic [iou_trk_pkg::CoordW-1:0]       rect_w_i,
  input  logic [iou_trk_pkg::CoordW-1:0]       rect_h_i,
  input  logic [iou_trk_pkg::FramesW-1:0]      frames_elapsed_i,
  output logic                                 res_valid_o,
  input  logic                                 res_ready_i,
  output logic                                 out_valid_o,
  output logic signed [iou_trk_pkg::CoordW-1:0] out_x_o,
  output logic signed [iou_trk_pkg::CoordW-1:0] out_y_o,
  output logic [iou_trk_pkg::CoordW-1:0]       out_w_o,
  output logic [iou_trk_pkg::CoordW-1:0]       out_h_o,
  output logic                                 out_last_o
);
  import iou_trk_pkg::*;

  localparam int CntW = $clog2(MAX_TRACKS + 1);
  localparam int IdxW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;

  // helpers
  function automatic logic on_scr(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
                                  input logic [CoordW-1:0] w, input logic [CoordW-1:0] h,
                                  input logic [FrameW-1:0] fw, input logic [FrameW-1:0] fh);
    logic signed [CoordW+1:0] xs, ys, xe, ye, xl, yl;
    xs = {{2{x[CoordW-1]}}, x};
    ys = {{2{y[CoordW-1]}}, y};
    xe = xs + $signed({2'b00, w});
    ye = ys + $signed({2'b00, h});
    xl = {2'b00, fw, 4'b0000};
    yl = {2'b00, fh, 4'b0000};
    return !(xe <= 0 || ye <= 0 || xs >= xl || ys >= yl);
  endfunction

  function automatic logic mov(input logic [CoordW-1:0] vx, input logic [CoordW-1:0] vy,
                               input logic [FrameW-1:0] ms);
    logic [CoordW-1:0] ax, ay;
    logic [CoordW:0]   s;
    ax = vx[CoordW-1] ? (~vx + 1'b1) : vx;
    ay = vy[CoordW-1] ? (~vy + 1'b1) : vy;
    s  = {1'b0, ax} + {1'b0, ay};
    return s > {{(CoordW+1-FrameW){1'b0}}, ms};
  endfunction

  function automatic logic [CoordW-1:0] sat20(input logic signed [32:0] v);
    logic [CoordW-1:0] r;
    if (v > 33'sd524287) r = 20'h7FFFF;
    else if (v < -33'sd524288) r = 20'h80000;
    else r = v[CoordW-1:0];
    return r;
  endfunction

  // configuration registers
  logic [FrameW-1:0] fw_q, fh_q, minspd_q;
  logic [RatioW-1:0] islow_q, ifast_q, blend_q;
  logic [MissW-1:0]  ev_q, evmov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q     <= FwRst;
      fh_q     <= FhRst;
      islow_q  <= IouSlowRst;
      ifast_q  <= IouFastRst;
      minspd_q <= MinSpdRst;
      ev_q     <= EvRst;
      evmov_q  <= EvMovRst;
      blend_q  <= BlendRst;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_FW:     fw_q     <= cfg_data_i;
        REG_FH:     fh_q     <= cfg_data_i;
        REG_ISLOW:  islow_q  <= cfg_data_i[RatioW-1:0];
        REG_IFAST:  ifast_q  <= cfg_data_i[RatioW-1:0];
        REG_MINSPD: minspd_q <= cfg_data_i;
        REG_EV:     ev_q     <= cfg_data_i[MissW-1:0];
        REG_EVMOV:  evmov_q  <= cfg_data_i[MissW-1:0];
        REG_BLEND:  blend_q  <= cfg_data_i[RatioW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and datapath registers
  state_e state_q, state_d;
  logic [1:0]              func_q;
  logic signed [CoordW-1:0] rx_q, ry_q;
  logic [CoordW-1:0]       rw_q, rh_q;
  logic [FramesW-1:0]      fe_q;
  logic [CntW-1:0]         cnt_q, j_q, wr_q;
  logic [IdxW-1:0]         bi_q;
  logic                    bi_v_q;
  logic [RatioW-1:0]       best_q, thr_q, q_q;
  logic [OutCntW-1:0]      n_q;
  logic [3:0]              k_q;
  logic [4:0]              bcnt_q;

  logic signed [29:0]      bx_q, by_q;
  logic [CoordW-1:0]       bw_q, bh_q;
  logic                    mv_q;
  logic [CoordW-1:0]       iwv_q, ihv_q;
  logic [AreaW-1:0]        ia_q, aa_q, ba_q;
  logic [AreaW:0]          ua_q;
  logic [AreaW+9:0]        rem_q, dv_q;

  logic signed [29:0]      p1_q  [2];
  logic signed [30:0]      dxw_q [2];
  logic [31:0]             dvd_q [2];
  logic [7:0]              brem_q [2];
  logic                    dneg_q [2];

  logic                    pend_v_q;
  logic [CoordW-1:0]       px_q, py_q, pw_q, ph_q;

  logic                    res_valid_q, ov_q, olast_q;
  logic [CoordW-1:0]       ox_q, oy_q, ow_q, oh_q;

  // track memory
  track_t            mem_q [MAX_TRACKS];
  track_t            rd_q, mem_wd;
  logic              mem_re, mem_we;
  logic [IdxW-1:0]   mem_ra, mem_wa;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    if (mem_re) rd_q <= mem_q[mem_ra];
  end

  // shared combinational terms
  logic              in_acc, out_free, scan_end, in_on, rd_on, match;
  logic [AreaW:0]    ua_sum;
  logic [RatioW-1:0] weff, cw, qf;
  logic signed [8:0] fs;
  logic signed [16:0] fhalf;
  logic signed [30:0] ax_lo, ax_hi, bx_hi, ay_lo, ay_hi, by_hi, lo_x, hi_x, lo_y, hi_y;
  logic signed [31:0] iw, ih;
  logic [CoordW-1:0] old_v [2], pos_v [2], in_v [2];
  logic signed [39:0] num [2];
  logic [8:0]        rn [2];
  logic              bge [2];
  logic signed [32:0] bv [2], hs [2];
  logic [MissW-1:0]  miss_n, lim;
  logic              keep;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !res_valid_q || res_ready_i;
  assign scan_end   = (j_q == cnt_q);
  assign in_on      = on_scr(rx_q, ry_q, rw_q, rh_q, fw_q, fh_q);
  assign rd_on      = on_scr(rd_q.pos_x, rd_q.pos_y, rd_q.size_w, rd_q.size_h, fw_q, fh_q);
  assign match      = bi_v_q && (best_q >= thr_q);
  assign ua_sum     = {1'b0, aa_q} + {1'b0, ba_q} - {1'b0, ia_q};
  assign weff       = (blend_q > 9'd256) ? 9'd256 : blend_q;
  assign cw         = 9'd256 - weff;
  assign fs         = $signed({1'b0, fe_q});
  // half of the divisor 256*f, for round half up
  assign fhalf      = $signed({2'b00, fe_q, 7'h00});
  assign qf         = (ua_q == '0) ? '0 : q_q;

  // intersection extents against the predicted rectangle
  always_comb begin
    ax_lo = rx_q;
    ax_hi = rx_q + $signed({1'b0, rw_q});
    bx_hi = bx_q + $signed({1'b0, bw_q});
    ay_lo = ry_q;
    ay_hi = ry_q + $signed({1'b0, rh_q});
    by_hi = by_q + $signed({1'b0, bh_q});
    lo_x  = (ax_lo > bx_q) ? ax_lo : 31'(bx_q);
    hi_x  = (ax_hi < bx_hi) ? ax_hi : bx_hi;
    lo_y  = (ay_lo > by_q) ? ay_lo : 31'(by_q);
    hi_y  = (ay_hi < by_hi) ? ay_hi : by_hi;
    iw    = hi_x - lo_x;
    ih    = hi_y - lo_y;
  end

  // per-axis lanes: blend, serial divide, predict
  always_comb begin
    old_v[0] = rd_q.vel_x;   old_v[1] = rd_q.vel_y;
    pos_v[0] = rd_q.pos_x;   pos_v[1] = rd_q.pos_y;
    in_v[0]  = rx_q;         in_v[1]  = ry_q;
    for (int l = 0; l < 2; l++) begin
      num[l] = p1_q[l] * fs + dxw_q[l] + fhalf;
      rn[l]  = {brem_q[l], dvd_q[l][31]};
      bge[l] = (rn[l] >= {1'b0, fe_q});
      bv[l]  = dneg_q[l] ? -$signed({1'b0, dvd_q[l]}) : $signed({1'b0, dvd_q[l]});
      hs[l]  = $signed(pos_v[l]) + $signed(old_v[l]) * fs;
    end
  end

  // aging of one track at end of frame
  always_comb begin
    miss_n = (!rd_q.hit && rd_q.miss != 8'hFF) ? rd_q.miss + 8'd1 : rd_q.miss;
    lim    = mov(rd_q.vel_x, rd_q.vel_y, minspd_q) ? evmov_q : ev_q;
    keep   = (miss_n < lim);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (func_e'(func_i))
            FN_DETECT:    state_d = ST_D_CHK;
            FN_END_FRAME: state_d = ST_E_RD;
            FN_PREDICT:   state_d = ST_H_RD;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_D_CHK:  state_d = in_on ? ST_D_RD : ST_IDLE;
      ST_D_RD:   state_d = scan_end ? ST_D_DEC : ST_D_PRED;
      ST_D_PRED: state_d = ST_D_INT;
      ST_D_INT:  state_d = ST_D_MUL;
      ST_D_MUL:  state_d = ST_D_UNI;
      ST_D_UNI:  state_d = ST_D_DIV;
      ST_D_DIV:  state_d = (k_q == 4'd0) ? ST_D_CMP : ST_D_DIV;
      ST_D_CMP:  state_d = ST_D_RD;
      ST_D_DEC:  state_d = match ? ST_B_MUL1 : ST_IDLE;
      ST_B_MUL1: state_d = ST_B_MUL2;
      ST_B_MUL2: state_d = ST_B_DIV;
      ST_B_DIV:  state_d = (bcnt_q == 5'd0) ? ST_B_WR : ST_B_DIV;
      ST_B_WR:   state_d = ST_IDLE;
      ST_E_RD:   state_d = scan_end ? ST_X_RD : ST_E_UPD;
      ST_E_UPD:  state_d = ST_E_RD;
      ST_H_RD:   state_d = scan_end ? ST_X_RD : ST_H_UPD;
      ST_H_UPD:  state_d = ST_H_RD;
      ST_X_RD:   state_d = (scan_end || n_q == OutCntW'(OutLimit)) ? ST_X_END : ST_X_CHK;
      ST_X_CHK:  state_d = (rd_on && pend_v_q && !out_free) ? ST_X_CHK : ST_X_RD;
      ST_X_END:  state_d = out_free ? ST_IDLE : ST_X_END;
      default:   state_d = ST_IDLE;
    endcase
  end

  // memory port controls
  always_comb begin
    mem_re = 1'b0;
    mem_ra = j_q[IdxW-1:0];
    mem_we = 1'b0;
    mem_wa = j_q[IdxW-1:0];
    mem_wd = rd_q;
    case (state_q)
      ST_D_RD, ST_E_RD, ST_H_RD, ST_X_RD: mem_re = !scan_end;
      ST_D_DEC: begin
        if (match) begin
          mem_re = 1'b1;
          mem_ra = bi_q;
        end else if (cnt_q < CntW'(MAX_TRACKS)) begin
          mem_we = 1'b1;
          mem_wa = cnt_q[IdxW-1:0];
          mem_wd = '{pos_x: rx_q, pos_y: ry_q, size_w: rw_q, size_h: rh_q,
                     vel_x: '0, vel_y: '0, miss: '0, hit: 1'b1};
        end
      end
      ST_B_WR: begin
        mem_we = 1'b1;
        mem_wa = bi_q;
        mem_wd = '{pos_x: rx_q, pos_y: ry_q, size_w: rw_q, size_h: rh_q,
                   vel_x: sat20(bv[0]), vel_y: sat20(bv[1]), miss: '0, hit: 1'b1};
      end
      ST_E_UPD: begin
        mem_we      = keep;
        mem_wa      = wr_q[IdxW-1:0];
        mem_wd.miss = miss_n;
        mem_wd.hit  = 1'b0;
      end
      ST_H_UPD: begin
        mem_we       = 1'b1;
        mem_wd.pos_x = sat20(hs[0]);
        mem_wd.pos_y = sat20(hs[1]);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      j_q      <= '0;
      wr_q     <= '0;
      n_q      <= '0;
      bi_v_q   <= 1'b0;
      pend_v_q <= 1'b0;
      k_q      <= '0;
      bcnt_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            j_q      <= '0;
            wr_q     <= '0;
            n_q      <= '0;
            bi_v_q   <= 1'b0;
            pend_v_q <= 1'b0;
            if (func_e'(func_i) == FN_CLEAR) cnt_q <= '0;
          end
        end
        ST_D_UNI: k_q <= 4'd8;
        ST_D_DIV: k_q <= k_q - 4'd1;
        ST_D_CMP: begin
          if (qf > best_q) bi_v_q <= 1'b1;
          j_q <= j_q + 1'b1;
        end
        ST_D_DEC: if (!match && cnt_q < CntW'(MAX_TRACKS)) cnt_q <= cnt_q + 1'b1;
        ST_B_MUL2: bcnt_q <= 5'd31;
        ST_B_DIV:  bcnt_q <= bcnt_q - 5'd1;
        ST_E_RD: begin
          if (scan_end) begin
            cnt_q <= wr_q;
            j_q   <= '0;
          end
        end
        ST_E_UPD: begin
          if (keep) wr_q <= wr_q + 1'b1;
          j_q <= j_q + 1'b1;
        end
        ST_H_RD:  if (scan_end) j_q <= '0;
        ST_H_UPD: j_q <= j_q + 1'b1;
        ST_X_CHK: begin
          if (!rd_on) begin
            j_q <= j_q + 1'b1;
          end else if (!(pend_v_q && !out_free)) begin
            pend_v_q <= 1'b1;
            n_q      <= n_q + 1'b1;
            j_q      <= j_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          func_q <= func_i;
          rx_q   <= rect_x_i;
          ry_q   <= rect_y_i;
          rw_q   <= rect_w_i;
          rh_q   <= rect_h_i;
          fe_q   <= (frames_elapsed_i == '0) ? 8'd1 : frames_elapsed_i;
          best_q <= '0;
          thr_q  <= islow_q;
        end
      end
      ST_D_PRED: begin
        bx_q <= $signed(rd_q.pos_x) + $signed(rd_q.vel_x) * $signed({1'b0, rd_q.miss});
        by_q <= $signed(rd_q.pos_y) + $signed(rd_q.vel_y) * $signed({1'b0, rd_q.miss});
        bw_q <= rd_q.size_w;
        bh_q <= rd_q.size_h;
        mv_q <= mov(rd_q.vel_x, rd_q.vel_y, minspd_q);
      end
      ST_D_INT: begin
        iwv_q <= (iw > 0 && ih > 0) ? iw[CoordW-1:0] : '0;
        ihv_q <= (iw > 0 && ih > 0) ? ih[CoordW-1:0] : '0;
      end
      ST_D_MUL: begin
        ia_q <= iwv_q * ihv_q;
        aa_q <= rw_q * rh_q;
        ba_q <= bw_q * bh_q;
      end
      ST_D_UNI: begin
        ua_q  <= ua_sum;
        rem_q <= {2'b00, ia_q, 8'h00};
        dv_q  <= {1'b0, ua_sum, 8'h00};
        q_q   <= '0;
      end
      // one quotient bit of 256*I/U per cycle
      ST_D_DIV: begin
        if (rem_q >= dv_q) begin
          rem_q <= rem_q - dv_q;
          q_q   <= {q_q[RatioW-2:0], 1'b1};
        end else begin
          q_q   <= {q_q[RatioW-2:0], 1'b0};
        end
        dv_q <= dv_q >> 1;
      end
      ST_D_CMP: begin
        if (qf > best_q) begin
          best_q <= qf;
          bi_q   <= j_q[IdxW-1:0];
          thr_q  <= mv_q ? ifast_q : islow_q;
        end
      end
      ST_B_MUL1: begin
        for (int l = 0; l < 2; l++) begin
          p1_q[l]  <= $signed(old_v[l]) * $signed({1'b0, weff});
          dxw_q[l] <= ($signed(in_v[l]) - $signed(pos_v[l])) * $signed({1'b0, cw});
        end
      end
      // floor division by f works on the magnitude, rounding down for negatives
      ST_B_MUL2: begin
        for (int l = 0; l < 2; l++) begin
          dneg_q[l] <= num[l][39];
          dvd_q[l]  <= num[l][39] ? (~num[l][39:8] + {24'h000000, fe_q}) : num[l][39:8];
          brem_q[l] <= '0;
        end
      end
      ST_B_DIV: begin
        for (int l = 0; l < 2; l++) begin
          brem_q[l] <= bge[l] ? 8'(rn[l] - {1'b0, fe_q}) : rn[l][7:0];
          dvd_q[l]  <= {dvd_q[l][30:0], bge[l]};
        end
      end
      ST_X_CHK: begin
        if (rd_on && !(pend_v_q && !out_free)) begin
          px_q <= rd_q.pos_x;
          py_q <= rd_q.pos_y;
          pw_q <= rd_q.size_w;
          ph_q <= rd_q.size_h;
        end
      end
      default: ;
    endcase
  end

  // output register: a listed track waits in the pending slot for the next one or the list end
  logic out_ld, out_fin;
  assign out_ld  = (state_q == ST_X_CHK && rd_on && pend_v_q && out_free) ||
                   (state_q == ST_X_END && out_free);
  assign out_fin = (state_q == ST_X_END);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (out_ld) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      ov_q    <= pend_v_q;
      ox_q    <= pend_v_q ? px_q : '0;
      oy_q    <= pend_v_q ? py_q : '0;
      ow_q    <= pend_v_q ? pw_q : '0;
      oh_q    <= pend_v_q ? ph_q : '0;
      olast_q <= out_fin;
    end
  end

  assign res_valid_o = res_valid_q;
  assign out_valid_o = ov_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign out_w_o     = ow_q;
  assign out_h_o     = oh_q;
  assign out_last_o  = olast_q;

  // the table never holds more than its depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_TRACKS))
    else $error("track count above table depth");

  // the empty-list marker always closes its list
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !out_valid_o |-> out_last_o)
    else $error("empty marker without last");

  // compaction never writes ahead of the read pointer
  a_compact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_E_UPD |-> wr_q <= j_q)
    else $error("compaction overtook scan");

  // clear empties the table, checked when the previous item was no clear
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && func_q != func_i && func_e'(func_i) == FN_CLEAR |=> cnt_q == '0)
    else $error("clear left tracks");

endmodule

/* verif/testbench.sv */
// testbench: self-checking bench for iou_region_tracker; directed rows, then random frames
// depends on iou_trk_pkg and iou_region_tracker; untyped rows are checked against a predictor
`timescale 1ns / 1ps

module testbench;
  import iou_trk_pkg::*;

  localparam int  NumTracks  = 16;
  localparam int  DrainWait  = 400;
  localparam int  LongHold   = 400;
  localparam longint CycleLimit = 3000000;
  localparam int  NumDirected = 20;

  typedef struct packed {
    logic              valid;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] w;
    logic [CoordW-1:0] h;
    logic              last;
  } track_beat_t;

  typedef struct {
    func_e                    fn;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [CoordW-1:0]        w;
    logic [CoordW-1:0]        h;
    logic [FramesW-1:0]       f;
    bit                       typed;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] func = '0;
  logic signed [CoordW-1:0] rect_x = '0, rect_y = '0;
  logic [CoordW-1:0] rect_w = '0, rect_h = '0;
  logic [FramesW-1:0] frames = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  logic out_valid, out_last;
  logic signed [CoordW-1:0] out_x, out_y;
  logic [CoordW-1:0] out_w, out_h;

  iou_region_tracker dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .func_i(func), .rect_x_i(rect_x), .rect_y_i(rect_y),
    .rect_w_i(rect_w), .rect_h_i(rect_h), .frames_elapsed_i(frames),
    .res_valid_o(res_valid), .res_ready_i(res_ready),
    .out_valid_o(out_valid), .out_x_o(out_x), .out_y_o(out_y),
    .out_w_o(out_w), .out_h_o(out_h), .out_last_o(out_last)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [CfgDataW-1:0]      reg_val [8];
  logic signed [CoordW-1:0] trk_x [NumTracks];
  logic signed [CoordW-1:0] trk_y [NumTracks];
  logic [CoordW-1:0]        trk_w [NumTracks];
  logic [CoordW-1:0]        trk_h [NumTracks];
  logic signed [CoordW-1:0] trk_vx [NumTracks];
  logic signed [CoordW-1:0] trk_vy [NumTracks];
  logic [MissW-1:0]         trk_miss [NumTracks];
  bit                       trk_hit [NumTracks];
  int                       trk_cnt;

  track_beat_t pending_tracks[$];
  int  errors = 0;
  int  items_sent = 0;
  int  beats_seen = 0;
  longint cycles = 0;
  bit  quiet_rx = 1'b0, quiet_tx = 1'b0, hold_req = 1'b0;

  function automatic longint sat_coord(longint v);
    if (v > 524287) return 524287;
    if (v < -524288) return -524288;
    return v;
  endfunction

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint iou_ratio(longint ax, longint ay, longint aw, longint ah,
                                       longint bx, longint by, longint bw, longint bh);
    longint iw, ih, inter, uni;
    iw = ((ax + aw < bx + bw) ? ax + aw : bx + bw) - ((ax > bx) ? ax : bx);
    ih = ((ay + ah < by + bh) ? ay + ah : by + bh) - ((ay > by) ? ay : by);
    inter = (iw > 0 && ih > 0) ? iw * ih : 0;
    uni = aw * ah + bw * bh - inter;
    if (uni == 0) return 0;
    return (inter * 256) / uni;
  endfunction

  function automatic bit visible(longint x, longint y, longint w, longint h);
    if (x + w <= 0 || y + h <= 0) return 1'b0;
    if (x >= longint'(reg_val[REG_FW]) * 16 || y >= longint'(reg_val[REG_FH]) * 16)
      return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit is_moving(int i);
    longint ax, ay;
    ax = longint'(trk_vx[i]);
    ay = longint'(trk_vy[i]);
    if (ax < 0) ax = -ax;
    if (ay < 0) ay = -ay;
    return (ax + ay) > longint'(reg_val[REG_MINSPD]);
  endfunction

  function automatic longint blend_vel(longint v, longint dx, longint f, longint w);
    longint num, d;
    num = v * w * f + dx * (256 - w);
    d = 256 * f;
    return sat_coord(floor_div(2 * num + d, 2 * d));
  endfunction

  // list on-screen tracks in table order, at most OutLimit, or the empty marker
  function automatic void list_tracks(ref track_beat_t q[$]);
    track_beat_t b;
    int n;
    n = 0;
    for (int i = 0; i < trk_cnt && n < OutLimit; i++) begin
      if (!visible(trk_x[i], trk_y[i], trk_w[i], trk_h[i])) continue;
      b = '{1'b1, trk_x[i], trk_y[i], trk_w[i], trk_h[i], 1'b0};
      q.push_back(b);
      n++;
    end
    if (n == 0) q.push_back('0);
    q[q.size()-1].last = 1'b1;
  endfunction

  function automatic void match_detection(longint x, longint y, longint w, longint h,
                                          longint f);
    longint best, thr, q, m, bw;
    int bi;
    best = 0;
    thr = reg_val[REG_ISLOW];
    bi = -1;
    if (!visible(x, y, w, h)) return;
    for (int j = 0; j < trk_cnt; j++) begin
      m = trk_miss[j];
      q = iou_ratio(x, y, w, h, longint'(trk_x[j]) + longint'(trk_vx[j]) * m,
                    longint'(trk_y[j]) + longint'(trk_vy[j]) * m,
                    longint'(trk_w[j]), longint'(trk_h[j]));
      if (q > best) begin
        best = q;
        bi = j;
        thr = is_moving(j) ? reg_val[REG_IFAST] : reg_val[REG_ISLOW];
      end
    end
    if (bi >= 0 && best >= thr) begin
      bw = (reg_val[REG_BLEND] > 256) ? 256 : reg_val[REG_BLEND];
      trk_vx[bi] = blend_vel(trk_vx[bi], x - longint'(trk_x[bi]), f, bw);
      trk_vy[bi] = blend_vel(trk_vy[bi], y - longint'(trk_y[bi]), f, bw);
      trk_x[bi] = x; trk_y[bi] = y; trk_w[bi] = w; trk_h[bi] = h;
      trk_miss[bi] = '0;
      trk_hit[bi] = 1'b1;
    end else if (trk_cnt < NumTracks) begin
      trk_x[trk_cnt] = x; trk_y[trk_cnt] = y; trk_w[trk_cnt] = w; trk_h[trk_cnt] = h;
      trk_vx[trk_cnt] = '0; trk_vy[trk_cnt] = '0;
      trk_miss[trk_cnt] = '0;
      trk_hit[trk_cnt] = 1'b1;
      trk_cnt++;
    end
  endfunction

  // age, evict and compact at the end of a frame
  function automatic void close_frame();
    int wr;
    longint lim;
    wr = 0;
    for (int i = 0; i < trk_cnt; i++) begin
      if (!trk_hit[i] && trk_miss[i] < 255) trk_miss[i]++;
      lim = is_moving(i) ? reg_val[REG_EVMOV] : reg_val[REG_EV];
      if (trk_miss[i] >= lim) continue;
      trk_x[wr] = trk_x[i]; trk_y[wr] = trk_y[i];
      trk_w[wr] = trk_w[i]; trk_h[wr] = trk_h[i];
      trk_vx[wr] = trk_vx[i]; trk_vy[wr] = trk_vy[i];
      trk_miss[wr] = trk_miss[i];
      wr++;
    end
    trk_cnt = wr;
    foreach (trk_hit[i]) trk_hit[i] = 1'b0;
  endfunction

  function automatic void clear_tracks();
    for (int i = 0; i < NumTracks; i++) begin
      trk_x[i] = '0; trk_y[i] = '0; trk_w[i] = '0; trk_h[i] = '0;
      trk_vx[i] = '0; trk_vy[i] = '0; trk_miss[i] = '0; trk_hit[i] = 1'b0;
    end
    trk_cnt = 0;
  endfunction

  // advance the predictor by one accepted beat, adding its listed tracks
  function automatic void track_step(func_e fn, longint x, longint y, longint w, longint h,
                                     longint f, ref track_beat_t q[$]);
    if (f == 0) f = 1;
    case (fn)
      FN_DETECT: match_detection(x, y, w, h, f);
      FN_END_FRAME: begin
        close_frame();
        list_tracks(q);
      end
      FN_PREDICT: begin
        for (int i = 0; i < trk_cnt; i++) begin
          trk_x[i] = sat_coord(longint'(trk_x[i]) + longint'(trk_vx[i]) * f);
          trk_y[i] = sat_coord(longint'(trk_y[i]) + longint'(trk_vy[i]) * f);
        end
        list_tracks(q);
      end
      default: clear_tracks();
    endcase
  endfunction

  // send one input beat and record what it should produce
  task automatic send_beat(stim_row_t r);
    int gap;
    track_beat_t scratch[$];
    gap = quiet_tx ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    func = r.fn; rect_x = r.x; rect_y = r.y; rect_w = r.w; rect_h = r.h; frames = r.f;
    in_valid = 1'b1;
    do @(posedge clk_i); while (!in_ready);
    track_step(r.fn, r.x, r.y, r.w, r.h, r.f, scratch);
    // typed rows: the empty-table marker is known without the predictor
    if (r.typed) pending_tracks.push_back('{1'b0, '0, '0, '0, '0, 1'b1});
    else foreach (scratch[i]) pending_tracks.push_back(scratch[i]);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_tracks.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [CfgDataW-1:0] val);
    logic [CfgDataW-1:0] mask;
    cfg_we = 1'b1; cfg_idx = idx; cfg_data = val;
    @(negedge clk_i);
    cfg_we = 1'b0;
    case (idx)
      REG_FW, REG_FH, REG_MINSPD: mask = 16'hFFFF;
      REG_EV, REG_EVMOV:          mask = 16'h00FF;
      default:                    mask = 16'h01FF;
    endcase
    reg_val[idx] = val & mask;
  endtask

  // result checker
  always @(posedge clk_i) begin
    track_beat_t want;
    if (rst_ni && res_valid && res_ready) begin
      beats_seen++;
      if (pending_tracks.size() == 0) begin
        $display("%0t: unexpected result beat x=%0d y=%0d", $time, out_x, out_y);
        errors++;
      end else begin
        want = pending_tracks.pop_front();
        if (out_valid !== want.valid || out_x !== want.x || out_y !== want.y ||
            out_w !== want.w || out_h !== want.h || out_last !== want.last) begin
          $display("%0t: mismatch exp v=%0b x=%0d y=%0d w=%0d h=%0d l=%0b", $time,
                   want.valid, $signed(want.x), $signed(want.y), want.w, want.h, want.last);
          $display("%0t:          got v=%0b x=%0d y=%0d w=%0d h=%0d l=%0b", $time,
                   out_valid, out_x, out_y, out_w, out_h, out_last);
          errors++;
        end
      end
    end
  end

  // result receiver with random stalls and one long hold-off on request
  initial begin
    int gap;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res_ready = 1'b0;
        repeat (LongHold) @(negedge clk_i);
      end
      gap = quiet_rx ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        res_ready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      res_ready = 1'b1;
      do @(posedge clk_i); while (!res_valid);
      @(negedge clk_i);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // random scene: a few objects moving across the frame
  int obj_x [4], obj_y [4], obj_vx [4], obj_vy [4], obj_w [4], obj_h [4];

  function automatic stim_row_t noise_row();
    stim_row_t r;
    r.fn = func_e'($urandom_range(0, 3));
    r.x = $urandom; r.y = $urandom; r.w = $urandom; r.h = $urandom; r.f = $urandom;
    r.typed = 1'b0;
    return r;
  endfunction

  task automatic run_frames(int n_items, int span_x, int span_y);
    stim_row_t r;
    int sent;
    sent = 0;
    foreach (obj_x[k]) begin
      obj_x[k] = $urandom_range(0, span_x); obj_y[k] = $urandom_range(0, span_y);
      obj_vx[k] = $signed($urandom_range(0, 160)) - 80;
      obj_vy[k] = $signed($urandom_range(0, 160)) - 80;
      obj_w[k] = $urandom_range(64, 2000); obj_h[k] = $urandom_range(64, 2000);
    end
    while (sent < n_items) begin
      r.typed = 1'b0;
      if ($urandom_range(0, 9) == 0) begin
        send_beat(noise_row());
        sent++;
        continue;
      end
      foreach (obj_x[k]) begin
        obj_x[k] += obj_vx[k]; obj_y[k] += obj_vy[k];
        if (obj_x[k] < -500 || obj_x[k] > span_x) obj_vx[k] = -obj_vx[k];
        if (obj_y[k] < -500 || obj_y[k] > span_y) obj_vy[k] = -obj_vy[k];
        if ($urandom_range(0, 9) < 7) begin
          r.fn = FN_DETECT;
          r.x = obj_x[k] + $signed($urandom_range(0, 32)) - 16;
          r.y = obj_y[k] + $signed($urandom_range(0, 32)) - 16;
          r.w = obj_w[k] + $urandom_range(0, 32);
          r.h = obj_h[k] + $urandom_range(0, 32);
          r.f = $urandom_range(0, 3);
          send_beat(r);
          sent++;
        end
      end
      r.fn = ($urandom_range(0, 4) == 0) ? FN_PREDICT : FN_END_FRAME;
      r.x = '0; r.y = '0; r.w = '0; r.h = '0;
      r.f = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
      send_beat(r);
      sent++;
      if ($urandom_range(0, 29) == 0) begin
        r.fn = FN_CLEAR;
        send_beat(r);
        sent++;
      end
    end
  endtask

  stim_row_t stim_rows [NumDirected];

  // stimulus
  initial begin
    logic [CfgDataW-1:0] phase_cfg [5][8];
    reg_val = '{FwRst, FhRst, IouSlowRst, IouFastRst, MinSpdRst, EvRst, EvMovRst, BlendRst};
    clear_tracks();
    stim_rows = '{
      '{FN_END_FRAME, 0, 0, 0, 0, 1, 1'b1},
      '{FN_PREDICT, 0, 0, 0, 0, 0, 1'b1},
      '{FN_DETECT, 16, 16, 320, 320, 1, 1'b0},
      '{FN_DETECT, 48, 32, 320, 320, 0, 1'b0},
      '{FN_DETECT, 48, 32, 320, 320, 255, 1'b0},
      '{FN_DETECT, 20000, 10000, 800, 600, 2, 1'b0},
      '{FN_DETECT, 0, 0, 0, 0, 1, 1'b0},
      '{FN_DETECT, 524287, 100, 50, 50, 1, 1'b0},
      '{FN_DETECT, 100, 524287, 50, 50, 1, 1'b0},
      '{FN_DETECT, -524288, -524288, 20'hFFFFF, 20'hFFFFF, 1, 1'b0},
      '{FN_DETECT, -100, -100, 100, 100, 1, 1'b0},
      '{FN_END_FRAME, 0, 0, 0, 0, 0, 1'b0},
      '{FN_DETECT, 96, 64, 320, 320, 1, 1'b0},
      '{FN_PREDICT, 0, 0, 0, 0, 255, 1'b0},
      '{FN_END_FRAME, 0, 0, 0, 0, 1, 1'b0},
      '{FN_END_FRAME, 0, 0, 0, 0, 1, 1'b0},
      '{FN_END_FRAME, 0, 0, 0, 0, 1, 1'b0},
      '{FN_CLEAR, 0, 0, 0, 0, 0, 1'b0},
      '{FN_END_FRAME, 0, 0, 0, 0, 1, 1'b1},
      '{FN_DETECT, 30000, 17000, 20'hFFFFF, 1, 7, 1'b0}
    };
    // per phase: fw fh slow fast minspd ev evmov blend
    phase_cfg = '{
      '{16'd1920, 16'd1080, 16'd0,   16'd0,   16'd0,     16'd1,   16'd255, 16'd0},
      '{16'd65535, 16'd65535, 16'd256, 16'd256, 16'd65535, 16'd255, 16'd1, 16'd256},
      '{16'd2000, 16'd1200, 16'd300, 16'd20, 16'd8, 16'd0, 16'd2, 16'd400},
      '{16'd1, 16'd1, 16'd100, 16'd50, 16'd32, 16'd4, 16'd8, 16'd128},
      '{16'd1920, 16'd1080, 16'd77, 16'd38, 16'd32, 16'd3, 16'd6, 16'd179}
    };
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (stim_rows[i]) send_beat(stim_rows[i]);
    drain_results();

    for (int p = 0; p < 5; p++) begin
      for (int k = 0; k < 8; k++) write_reg(reg_e'(k), phase_cfg[p][k]);
      quiet_tx = (p == 2);
      quiet_rx = (p == 2);
      if (p == 1) hold_req = 1'b1;
      if (p == 3) run_frames(20, 40, 40);
      else run_frames(30, 33000, 18000);
      quiet_tx = 1'b0;
      quiet_rx = 1'b0;
      // pause the sender until the block has caught up
      drain_results();
      if (p == 3) continue;
      run_frames(30, 33000, 18000);
      drain_results();
    end

    $display("run covered %0d input beats and %0d result beats over five register settings",
             items_sent, beats_seen);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

/* filelist.f */
src/iou_trk_pkg.sv
src/iou_region_tracker.sv
verif/testbench.sv
